/* sv/psvm_pkg.sv */
// ----------------------------------------------------------------------------
// psvm_pkg: shared types and constants of the sample voice mixer
// Transaction payloads, op and status codes, sequencer states and sizes.
// ----------------------------------------------------------------------------
package psvm_pkg;

  localparam int VOICES        = 256;
  localparam int REGIONS       = 128;
  localparam int MEM_ADDR_BITS = 20;
  localparam int MAX_CHANNELS  = 8;

  localparam int VIDX_W = $clog2(VOICES);
  localparam int RIDX_W = $clog2(REGIONS);
  localparam int RCNT_W = $clog2(REGIONS + 1);
  localparam int CH_W   = 3;
  localparam int POS_W  = 21;

  localparam logic [15:0] FULL_GAIN = 16'h8000;

  typedef enum logic [2:0] {
    OP_WRITE_MEM  = 3'd0,
    OP_ADD_REGION = 3'd1,
    OP_START      = 3'd2,
    OP_VOICE_ON   = 3'd3,
    OP_VOICE_OFF  = 3'd4,
    OP_TICK       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FINISH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_VRD,
    S_VCHK,
    S_DMUL,
    S_DIV,
    S_MRD,
    S_MMUL,
    S_MACC,
    S_VWB,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [19:0]        mem_address;
    logic signed [15:0] mem_data;
    logic [7:0]         pitch;
    logic [19:0]        region_start;
    logic [20:0]        region_end;
    logic [7:0]         voice_index;
    logic [15:0]        intensity;
    logic [15:0]        release_frames;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         channel;
    logic signed [23:0] mix_value;
    logic               last;
  } res_t;

endpackage

/* sv/polyphonic_sample_voice_mixer_core.sv */
// ----------------------------------------------------------------------------
// polyphonic_sample_voice_mixer_core: polyphonic sample player and mixer
// Sample memory, region table and voice slots, one frame mixed per tick.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time; cmd_ready is high only while
// the sequencer is idle, and a command may be taken while the previous result
// still waits in the output register. Memory writes, region appends, start and
// voice off go straight to the finish state. Voice on reads, then compares
// each region table entry. A tick walks all 256 voice slots through one shared
// multiplier; an active slot may take the release weight divide (16-step
// restoring divider), then is mixed per channel. Results follow at one
// channel per cycle while the output is free. Before start, ticks return zeros.
module polyphonic_sample_voice_mixer_core
  import psvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // memories
  logic [15:0]                  smem [2**MEM_ADDR_BITS];
  logic [15:0]                  smem_q;
  logic [48:0]                  rtab [REGIONS];
  logic [48:0]                  rtab_q;
  logic [2*POS_W-1:0]           vpos [VOICES];
  logic [2*POS_W-1:0]           vpos_q;
  logic [47:0]                  venv [VOICES];
  logic [47:0]                  venv_q;

  // control and datapath registers
  state_t                       state, state_next;
  cmd_t                         cmd_q;
  status_t                      status_q;
  logic [3:0]                   channel_count;
  logic                         running;
  logic [RCNT_W-1:0]            rcount;
  logic [RIDX_W-1:0]            rsel;
  logic [VOICES-1:0]            active;
  logic [VOICES-1:0]            releasing;
  logic [VIDX_W-1:0]            vidx;
  logic [CH_W-1:0]              ch;
  logic [POS_W-1:0]             cur_pos;
  logic [15:0]                  weight;
  logic signed [33:0]           prod;
  logic [31:0]                  dsh;
  logic [3:0]                   dcnt;
  logic signed [23:0]           acc [MAX_CHANNELS];

  logic [CH_W-1:0]              nc_m1;
  logic                         cmd_fire;
  logic                         out_free;
  logic                         out_load;
  res_t                         out_next;
  logic                         cfg_wr;

  // fields of the voice read data
  logic [POS_W-1:0]             rd_pos, rd_end;
  logic [15:0]                  rd_gain, rd_total, rd_left;
  assign rd_pos   = vpos_q[2*POS_W-1:POS_W];
  assign rd_end   = vpos_q[POS_W-1:0];
  assign rd_gain  = venv_q[47:32];
  assign rd_total = venv_q[31:16];
  assign rd_left  = venv_q[15:0];

  // shared multiplier operands
  logic signed [16:0]           mul_a, mul_b;
  always_comb begin
    if (state == S_DMUL) begin
      mul_a = {1'b0, rd_gain};
      mul_b = {1'b0, rd_left};
    end else begin
      mul_a = {smem_q[15], smem_q};
      mul_b = {1'b0, weight};
    end
  end

  // divider step
  logic [31:0]                  dsrc, dstep;
  logic [16:0]                  dcand;
  always_comb begin
    dsrc  = (dcnt == 4'd0) ? prod[31:0] : dsh;
    dcand = {dsrc[31:16], dsrc[15]};
    if (dcand >= {1'b0, rd_total}) begin
      dstep = {16'(dcand - {1'b0, rd_total}), dsrc[14:0], 1'b1};
    end else begin
      dstep = {dcand[15:0], dsrc[14:0], 1'b0};
    end
  end

  // clamp channel count
  always_comb begin
    if (channel_count == 4'd0) begin
      nc_m1 = '0;
    end else if (channel_count > 4'(MAX_CHANNELS)) begin
      nc_m1 = CH_W'(MAX_CHANNELS - 1);
    end else begin
      nc_m1 = CH_W'(channel_count - 4'd1);
    end
  end

  assign cmd_fire = cmd_valid && cmd_ready;
  assign out_free = !res_valid || res_ready;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = {28'd0, channel_count};

  logic                         voice_ok;
  logic                         region_hit;
  assign voice_ok   = {1'b0, cmd_q.voice_index} < (VIDX_W + 1)'(VOICES);
  assign region_hit = rtab_q[48:41] == cmd_q.pitch;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd.op)
            OP_VOICE_ON: state_next = (rcount == '0) ? S_FINISH : S_SRCH_RD;
            OP_TICK:     state_next = running ? S_VRD : S_EMIT;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_FINISH:   if (out_free) state_next = S_IDLE;
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (region_hit || (RCNT_W'(rsel) + RCNT_W'(1) == rcount)) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_VRD: begin
        if (active[vidx]) begin
          state_next = S_VCHK;
        end else if (vidx == VIDX_W'(VOICES - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_VCHK: begin
        if (rd_pos >= rd_end || rd_left == 16'd0) begin
          state_next = (vidx == VIDX_W'(VOICES - 1)) ? S_EMIT : S_VRD;
        end else if (releasing[vidx] && rd_total != 16'd0) begin
          state_next = S_DMUL;
        end else begin
          state_next = S_MRD;
        end
      end
      S_DMUL:  state_next = S_DIV;
      S_DIV:   if (dcnt == 4'd15) state_next = S_MRD;
      S_MRD:   state_next = S_MMUL;
      S_MMUL:  state_next = S_MACC;
      S_MACC:  state_next = (ch == nc_m1) ? S_VWB : S_MRD;
      S_VWB:   state_next = (vidx == VIDX_W'(VOICES - 1)) ? S_EMIT : S_VRD;
      S_EMIT:  if (out_free && ch == nc_m1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and result outputs
  always_comb begin
    cmd_ready = (state == S_IDLE);
    out_load  = 1'b0;
    out_next  = '0;
    case (state)
      S_FINISH: begin
        out_load        = out_free;
        out_next.status = status_q;
        out_next.last   = 1'b1;
      end
      S_EMIT: begin
        out_load           = out_free;
        out_next.status    = ST_OK;
        out_next.channel   = ch;
        out_next.mix_value = acc[ch];
        out_next.last      = (ch == nc_m1);
      end
      default: out_load = 1'b0;
    endcase
  end

  // memory read ports, registered
  always_ff @(posedge clk) begin
    smem_q <= smem[cur_pos[MEM_ADDR_BITS-1:0]];
    rtab_q <= rtab[rsel];
    vpos_q <= vpos[vidx];
    venv_q <= venv[vidx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      channel_count <= 4'd1;
      running       <= 1'b0;
      rcount        <= '0;
      active        <= '0;
      releasing     <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_wr) channel_count <= pwdata[3:0];
      if (cmd_fire) begin
        case (cmd.op)
          OP_ADD_REGION: if (rcount < RCNT_W'(REGIONS)) rcount <= rcount + RCNT_W'(1);
          OP_START: begin
            active    <= '0;
            releasing <= '0;
            running   <= 1'b1;
          end
          OP_VOICE_OFF: releasing[cmd.voice_index] <= 1'b1;
          default: running <= running;
        endcase
      end
      if (state == S_SRCH_CMP && region_hit && voice_ok) begin
        active[cmd_q.voice_index[VIDX_W-1:0]]    <= 1'b1;
        releasing[cmd_q.voice_index[VIDX_W-1:0]] <= 1'b0;
      end
      if (state == S_VCHK && (rd_pos >= rd_end || rd_left == 16'd0)) begin
        active[vidx] <= 1'b0;
      end
    end
  end

  // datapath and memory writes
  always_ff @(posedge clk) begin
    if (out_load) res <= out_next;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          cmd_q    <= cmd;
          status_q <= ST_OK;
          rsel     <= '0;
          vidx     <= '0;
          ch       <= '0;
          for (int c = 0; c < MAX_CHANNELS; c++) acc[c] <= '0;
          case (cmd.op)
            OP_WRITE_MEM: smem[cmd.mem_address[MEM_ADDR_BITS-1:0]] <= cmd.mem_data;
            OP_ADD_REGION: begin
              if (rcount < RCNT_W'(REGIONS)) begin
                rtab[rcount[RIDX_W-1:0]] <= {cmd.pitch, cmd.region_start, cmd.region_end};
              end else begin
                status_q <= ST_FULL;
              end
            end
            OP_VOICE_ON: if (rcount == '0) status_q <= ST_NOT_FOUND;
            default: status_q <= ST_OK;
          endcase
        end
      end
      S_SRCH_CMP: begin
        if (region_hit) begin
          if (voice_ok) begin
            vpos[cmd_q.voice_index[VIDX_W-1:0]] <= {1'b0, rtab_q[40:21], rtab_q[20:0]};
            venv[cmd_q.voice_index[VIDX_W-1:0]] <= {
              (cmd_q.intensity > FULL_GAIN) ? FULL_GAIN : cmd_q.intensity,
              cmd_q.release_frames, cmd_q.release_frames};
          end
        end else if (RCNT_W'(rsel) + RCNT_W'(1) == rcount) begin
          status_q <= ST_NOT_FOUND;
        end else begin
          rsel <= rsel + RIDX_W'(1);
        end
      end
      S_VRD: begin
        if (!active[vidx] && vidx != VIDX_W'(VOICES - 1)) vidx <= vidx + VIDX_W'(1);
      end
      S_VCHK: begin
        cur_pos <= rd_pos;
        ch      <= '0;
        dcnt    <= '0;
        weight  <= releasing[vidx] ? 16'd0 : rd_gain;
        if ((rd_pos >= rd_end || rd_left == 16'd0) && vidx != VIDX_W'(VOICES - 1)) begin
          vidx <= vidx + VIDX_W'(1);
        end
      end
      S_DMUL: prod <= mul_a * mul_b;
      S_DIV: begin
        dsh  <= dstep;
        dcnt <= dcnt + 4'd1;
        if (dcnt == 4'd15) weight <= dstep[15:0];
      end
      S_MMUL: begin
        prod    <= mul_a * mul_b;
        cur_pos <= cur_pos + POS_W'(1);
      end
      S_MACC: begin
        acc[ch] <= acc[ch] + {{5{prod[33]}}, prod[33:15]};
        if (ch != nc_m1) ch <= ch + CH_W'(1);
      end
      S_VWB: begin
        vpos[vidx] <= {cur_pos, rd_end};
        venv[vidx] <= {rd_gain, rd_total,
                       releasing[vidx] ? rd_left - 16'd1 : rd_left};
        ch <= '0;
        if (vidx != VIDX_W'(VOICES - 1)) vidx <= vidx + VIDX_W'(1);
      end
      S_EMIT: begin
        if (out_free && ch != nc_m1) ch <= ch + CH_W'(1);
      end
      default: dcnt <= dcnt;
    endcase
    if (state == S_VRD && !active[vidx] && vidx == VIDX_W'(VOICES - 1)) ch <= '0;
    if (state == S_VCHK && (rd_pos >= rd_end || rd_left == 16'd0)) ch <= '0;
  end

endmodule
